// ----- rtl/rskg_pkg.sv -----
// Package for the small RSA key generator: widths, status codes, defaults.
// Used by the controller, the datapath and the top level. No dependencies.
package rskg_pkg;
   localparam int MinWidth = 32;
   localparam int PrimeWidth = 17;
   localparam int ModWidth = 33;
   localparam int ExpWidth = 7;
   localparam int StatusWidth = 2;
   localparam int WideWidth = 40;
   localparam int DefWindowHalf = 50;
   localparam int DefExponentLimit = 100;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK = 2'd0,
      STATUS_NO_PAIR = 2'd1,
      STATUS_NO_EXP = 2'd2
   } status_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_SQRT, OP_CAND_INIT, OP_TRIAL_INIT, OP_TRIAL_STEP,
      OP_ACCEPT_PRIME, OP_NEXT_CAND, OP_EXP_INIT, OP_GCD_STEP, OP_GCD_SWAP,
      OP_NEXT_EXP, OP_PHI, OP_D_STEP, OP_DIV_STEP, OP_GCD_UPDATE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic flag;
      logic end_flag;
   } stat_type;
endpackage

// ----- rtl/rskg_divider.sv -----
// Restoring radix-2 divider: one quotient bit per cycle.
// Depends on rskg_pkg for the wide operand width.
module rskg_divider
   import rskg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WideWidth-1:0] dividend,
   input  logic [WideWidth-1:0] divisor,
   output logic                 busy,
   output logic [WideWidth-1:0] quotient,
   output logic [WideWidth-1:0] remainder
);
   localparam int CntWidth = $clog2(WideWidth + 1);
   logic [WideWidth-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [WideWidth:0] trial;

   // One shift-subtract step per cycle while the counter runs.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[WideWidth-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CntWidth'(WideWidth);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = WideWidth'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[WideWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[WideWidth-1:0];
            quo_in = {quo_ff[WideWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = (cnt_ff != '0) || start;
   assign quotient = quo_ff;
   assign remainder = rem_ff;
endmodule

// ----- rtl/rskg_datapath.sv -----
// Datapath of the key generator: square root, candidate, trial divisor, gcd, d search.
// Depends on rskg_pkg and rskg_divider.
module rskg_datapath
   import rskg_pkg::*;
#(
   parameter int WINDOW_HALF = DefWindowHalf,
   parameter int EXPONENT_LIMIT = DefExponentLimit
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [MinWidth-1:0]    req_min_modulus,
   output logic [PrimeWidth-1:0]  p_out,
   output logic [PrimeWidth-1:0]  q_out,
   output logic [ModWidth-1:0]    n_out,
   output logic [ExpWidth-1:0]    e_out,
   output logic [ModWidth-1:0]    d_out
);
   localparam int EW = $clog2(EXPONENT_LIMIT + 1);
   localparam int SW = 18;

   // Working registers.
   logic [MinWidth-1:0] bound_ff;
   logic [MinWidth-1:0] t_ff, sbit_ff;
   logic [MinWidth-1:0] sv_ff;
   logic signed [SW:0] cand_ff, cend_ff;
   logic [SW-1:0] div_ff;
   logic [PrimeWidth-1:0] prev_ff, p_ff, q_ff;
   logic have_ff;
   logic [EW-1:0] e_ff;
   logic [WideWidth-1:0] ga_ff, gb_ff, kphi_ff, phi_ff;
   logic gsel_ff, fail_ff;
   logic [ModWidth-1:0] d_ff, n_ff;
   logic [WideWidth-1:0] dvd, dvs;
   logic div_start, div_busy;
   logic [WideWidth-1:0] quo, rem;
   logic [MinWidth:0] sq_try;
   logic [WideWidth-1:0] cand_u, prod;
   logic trial_over;

   rskg_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd),
      .divisor(dvs), .busy(div_busy), .quotient(quo), .remainder(rem)
   );

   assign cand_u = WideWidth'(unsigned'(cand_ff[SW-1:0]));
   assign sq_try = {1'b0, sv_ff} - {1'b0, t_ff} - {1'b0, sbit_ff};
   assign prod = WideWidth'(prev_ff) * cand_u;
   // The divisor has passed the square root of the candidate.
   assign trial_over = (WideWidth'(div_ff) * WideWidth'(div_ff) > cand_u);

   // Divider operands per operation.
   always_comb begin
      dvd = '0;
      dvs = 40'd1;
      div_start = 1'b0;
      case (cmd.op)
         OP_TRIAL_STEP: begin
            dvd = cand_u;
            dvs = WideWidth'(div_ff);
            div_start = !trial_over;
         end
         OP_GCD_STEP: begin
            dvd = ga_ff;
            dvs = gb_ff;
            div_start = (gb_ff != '0);
         end
         OP_D_STEP: begin
            dvd = kphi_ff + phi_ff + 1'b1;
            dvs = WideWidth'(e_ff);
            div_start = 1'b1;
         end
         default: ;
      endcase
   end

   // Status back to the controller.
   always_comb begin
      stat.done = !div_busy;
      stat.flag = 1'b0;
      stat.end_flag = 1'b0;
      case (cmd.op)
         OP_SQRT: stat.flag = (sbit_ff == '0);
         OP_CAND_INIT, OP_NEXT_CAND: stat.end_flag = (cand_ff >= cend_ff);
         // Prefilter: below 2, even, or 3, 5 or 7 themselves. Larger multiples
         // of 3, 5 and 7 are caught by the trial division.
         OP_TRIAL_INIT: stat.flag = (cand_ff < 19'sd2) || !cand_ff[0] ||
            (cand_u == 40'd3) || (cand_u == 40'd5) || (cand_u == 40'd7);
         OP_TRIAL_STEP: begin
            stat.flag = trial_over;
            stat.end_flag = 1'b0;
         end
         OP_ACCEPT_PRIME: stat.flag = have_ff && (prod > WideWidth'(bound_ff));
         OP_GCD_STEP: stat.flag = (gb_ff == '0);
         OP_GCD_SWAP: stat.flag = gsel_ff;
         OP_NEXT_EXP: begin
            stat.flag = !fail_ff;
            stat.end_flag = (e_ff >= EW'(EXPONENT_LIMIT - 1));
         end
         OP_DIV_STEP: stat.flag = (rem == '0) && (quo >= 40'd3);
         default: ;
      endcase
      if (cmd.op == OP_GCD_SWAP) stat.end_flag = fail_ff;
   end

   // Register updates.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            bound_ff <= req_min_modulus;
            sv_ff <= req_min_modulus;
            t_ff <= '0;
            sbit_ff <= MinWidth'(1) << (MinWidth - 2);
         end
         OP_SQRT: if (sbit_ff != '0) begin
            if (!sq_try[MinWidth]) begin
               sv_ff <= sq_try[MinWidth-1:0];
               t_ff <= (t_ff >> 1) + sbit_ff;
            end else begin
               t_ff <= t_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
         end
         OP_CAND_INIT: begin
            cand_ff <= $signed({1'b0, t_ff[SW-1:0]}) - (SW+1)'(WINDOW_HALF);
            cend_ff <= $signed({1'b0, t_ff[SW-1:0]}) + (SW+1)'(WINDOW_HALF);
            have_ff <= 1'b0;
         end
         OP_TRIAL_INIT: div_ff <= SW'(2);
         OP_TRIAL_STEP: ;
         OP_DIV_STEP: begin
            // Trial division result, or d search result.
            if (rem == '0) fail_ff <= 1'b1; else fail_ff <= 1'b0;
            div_ff <= div_ff + 1'b1;
            d_ff <= quo[ModWidth-1:0];
            kphi_ff <= kphi_ff + phi_ff;
         end
         OP_ACCEPT_PRIME: begin
            if (have_ff && prod > WideWidth'(bound_ff)) begin
               p_ff <= prev_ff;
               q_ff <= cand_u[PrimeWidth-1:0];
            end
            prev_ff <= cand_u[PrimeWidth-1:0];
            have_ff <= 1'b1;
         end
         OP_NEXT_CAND: cand_ff <= cand_ff + 1'b1;
         OP_EXP_INIT: begin
            e_ff <= EW'(3);
            ga_ff <= WideWidth'(p_ff) - 1'b1;
            gb_ff <= 40'd3;
            gsel_ff <= 1'b0;
            fail_ff <= 1'b0;
            n_ff <= ModWidth'(WideWidth'(p_ff) * WideWidth'(q_ff));
         end
         // One Euclid step once the division has finished.
         OP_GCD_UPDATE: begin
            ga_ff <= gb_ff;
            gb_ff <= rem;
         end
         OP_GCD_SWAP: begin
            // ga holds a finished gcd: first p-1 then q-1.
            if (!gsel_ff) begin
               ga_ff <= WideWidth'(q_ff) - 1'b1;
               gb_ff <= WideWidth'(e_ff);
               gsel_ff <= 1'b1;
               fail_ff <= (ga_ff != 40'd1);
            end else begin
               fail_ff <= fail_ff || (ga_ff != 40'd1);
            end
         end
         OP_NEXT_EXP: if (fail_ff) begin
            e_ff <= e_ff + 1'b1;
            ga_ff <= WideWidth'(p_ff) - 1'b1;
            gb_ff <= WideWidth'(e_ff + 1'b1);
            gsel_ff <= 1'b0;
            fail_ff <= 1'b0;
         end
         OP_PHI: begin
            phi_ff <= (WideWidth'(p_ff) - 1'b1) * (WideWidth'(q_ff) - 1'b1);
            kphi_ff <= '0;
         end
         default: ;
      endcase
   end

   assign p_out = p_ff;
   assign q_out = q_ff;
   assign n_out = n_ff;
   assign e_out = ExpWidth'(e_ff);
   assign d_out = d_ff;
endmodule

// ----- rtl/rskg_controller.sv -----
// Sequencer of the key generator: walks the search phases, drives the datapath.
// Depends on rskg_pkg.
module rskg_controller
   import rskg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cmd_type     cmd,
   input  stat_type    stat,
   output status_type  status_out
);
   typedef enum logic [3:0] {
      S_IDLE, S_SQRT, S_CINIT, S_TINIT, S_TSTEP, S_TWAIT, S_ACC, S_NEXT,
      S_EINIT, S_GSTEP, S_GWAIT, S_GSWAP, S_NEXP, S_PHI, S_DSTEP, S_DWAIT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;

   // Next state and command.
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in = status_ff;
      cmd.op = OP_NONE;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid && !rsp_valid_ff) begin
            cmd.op = OP_LOAD;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            if (stat.flag) state_in = S_CINIT;
         end
         S_CINIT: begin
            cmd.op = OP_CAND_INIT;
            state_in = S_TINIT;
         end
         S_TINIT: begin
            cmd.op = OP_TRIAL_INIT;
            if (stat.flag) state_in = S_NEXT;
            else state_in = S_TSTEP;
         end
         S_TSTEP: begin
            cmd.op = OP_TRIAL_STEP;
            if (stat.flag) state_in = S_ACC;
            else state_in = S_TWAIT;
         end
         // A zero remainder with a quotient of at least three marks the candidate as composite.
         S_TWAIT: if (stat.done) begin
            cmd.op = OP_DIV_STEP;
            if (stat.flag) state_in = S_NEXT;
            else state_in = S_TSTEP;
         end
         S_ACC: begin
            cmd.op = OP_ACCEPT_PRIME;
            if (stat.flag) state_in = S_EINIT;
            else state_in = S_NEXT;
         end
         S_NEXT: begin
            cmd.op = OP_NEXT_CAND;
            state_in = S_TINIT;
            if (stat.end_flag) begin
               state_in = S_IDLE;
               status_in = STATUS_NO_PAIR;
               rsp_valid_in = 1'b1;
            end
         end
         S_EINIT: begin
            cmd.op = OP_EXP_INIT;
            state_in = S_GSTEP;
         end
         S_GSTEP: begin
            cmd.op = OP_GCD_STEP;
            if (stat.flag) state_in = S_GSWAP;
            else state_in = S_GWAIT;
         end
         S_GWAIT: if (stat.done) begin
            cmd.op = OP_GCD_UPDATE;
            state_in = S_GSTEP;
         end
         S_GSWAP: begin
            cmd.op = OP_GCD_SWAP;
            if (!stat.flag) state_in = S_GSTEP;
            else state_in = S_NEXP;
         end
         // Keep the exponent if both gcds were one, else try the next one, or report no exponent at the limit.
         S_NEXP: begin
            cmd.op = OP_NEXT_EXP;
            if (stat.flag) begin
               state_in = S_PHI;
            end else if (stat.end_flag) begin
               state_in = S_IDLE;
               status_in = STATUS_NO_EXP;
               rsp_valid_in = 1'b1;
            end else begin
               state_in = S_GSTEP;
            end
         end
         S_PHI: begin
            cmd.op = OP_PHI;
            state_in = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.op = OP_D_STEP;
            state_in = S_DWAIT;
         end
         S_DWAIT: if (stat.done) begin
            cmd.op = OP_DIV_STEP;
            if (stat.flag) begin
               state_in = S_IDLE;
               status_in = STATUS_OK;
               rsp_valid_in = 1'b1;
            end else state_in = S_DSTEP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff <= status_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign status_out = status_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_from_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (state_ff == S_IDLE)) else $error("rsp outside idle");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready) else $error("accepted with result pending");
`endif
endmodule

// ----- rtl/rsa_small_key_generator.sv -----
// Small RSA key generator: one key set per input beat.
// Latency is data dependent: each trial divisor, gcd step and d candidate
// goes through the serial divider, so a prime candidate near the top of the
// range costs the most per candidate and large bounds take the longest. One
// item at a time; the next beat can be taken in the cycle after the result
// beat is taken. Synchronous active-high reset clears the controller; no
// result is pending. Depends on rskg_pkg, controller, datapath.
module rsa_small_key_generator
   import rskg_pkg::*;
#(
   parameter int WINDOW_HALF = DefWindowHalf,
   parameter int EXPONENT_LIMIT = DefExponentLimit
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MinWidth-1:0]    req_min_modulus,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PrimeWidth-1:0]  rsp_prime_p,
   output logic [PrimeWidth-1:0]  rsp_prime_q,
   output logic [ModWidth-1:0]    rsp_modulus,
   output logic [ExpWidth-1:0]    rsp_public_exponent,
   output logic [ModWidth-1:0]    rsp_private_exponent,
   output logic [StatusWidth-1:0] rsp_status
);
   cmd_type cmd;
   stat_type stat;
   status_type st;
   logic [PrimeWidth-1:0] p, q;
   logic [ModWidth-1:0] n, d;
   logic [ExpWidth-1:0] e;
   logic ok;

   rskg_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .stat(stat),
      .status_out(st)
   );

   rskg_datapath #(.WINDOW_HALF(WINDOW_HALF), .EXPONENT_LIMIT(EXPONENT_LIMIT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_min_modulus(req_min_modulus), .p_out(p), .q_out(q), .n_out(n),
      .e_out(e), .d_out(d)
   );

   // Fields are zero unless the key set completed.
   assign ok = (st == STATUS_OK);
   assign rsp_prime_p = ok ? p : '0;
   assign rsp_prime_q = ok ? q : '0;
   assign rsp_modulus = ok ? n : '0;
   assign rsp_public_exponent = ok ? e : '0;
   assign rsp_private_exponent = ok ? d : '0;
   assign rsp_status = st;
endmodule

// ----- bench/rsa_small_key_generator_checker.sv -----
// Checker for the small RSA key generator: predicts each key set from the
// accepted request beat and compares it with the response beat.
// Depends on rskg_pkg for widths and status codes.
module rsa_small_key_generator_checker
   import rskg_pkg::*;
#(
   parameter int WINDOW_HALF = DefWindowHalf,
   parameter int EXPONENT_LIMIT = DefExponentLimit
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [MinWidth-1:0]    req_min_modulus,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [PrimeWidth-1:0]  rsp_prime_p,
   input  logic [PrimeWidth-1:0]  rsp_prime_q,
   input  logic [ModWidth-1:0]    rsp_modulus,
   input  logic [ExpWidth-1:0]    rsp_public_exponent,
   input  logic [ModWidth-1:0]    rsp_private_exponent,
   input  logic [StatusWidth-1:0] rsp_status,
   output int                     fail_count,
   output int                     keys_waiting,
   output int                     keys_checked
);

   typedef struct {
      logic [PrimeWidth-1:0] p;
      logic [PrimeWidth-1:0] q;
      logic [ModWidth-1:0]   n;
      logic [ExpWidth-1:0]   e;
      logic [ModWidth-1:0]   d;
      status_type            status;
   } key_set_type;

   key_set_type expected_keys[$];

   // Integer square root by bisection.
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 32;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   // Primality as the block sees it: 2, 3, 5 and 7 are filtered out.
   function automatic bit is_key_prime(input longint c);
      longint unsigned u, lim;
      if (c < 2) return 0;
      u = c;
      if (u % 2 == 0 || u % 3 == 0 || u % 5 == 0 || u % 7 == 0) return 0;
      lim = int_sqrt(u);
      for (longint unsigned j = 2; j <= lim; j++)
         if (u % j == 0) return 0;
      return 1;
   endfunction

   function automatic longint unsigned gcd_of(input longint unsigned a,
                                              input longint unsigned b);
      longint unsigned r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Full key computation for one bound.
   function automatic key_set_type compute_key_set(input logic [MinWidth-1:0] bound);
      key_set_type ks;
      longint t, c;
      longint unsigned prev, p, q, e, d, phi, x;
      bit have_prev, found;
      ks = '{default: '0, status: STATUS_OK};
      prev = 0;
      p = 0;
      q = 0;
      e = 0;
      d = 0;
      have_prev = 0;
      found = 0;
      t = longint'(int_sqrt(longint'(bound)));
      for (c = t - WINDOW_HALF; c <= t + WINDOW_HALF && !found; c++) begin
         if (is_key_prime(c)) begin
            if (have_prev && prev * longint'(c) > longint'(bound)) begin
               p = prev;
               q = c;
               found = 1;
            end else begin
               prev = c;
               have_prev = 1;
            end
         end
      end
      if (!found) begin
         ks.status = STATUS_NO_PAIR;
         return ks;
      end
      found = 0;
      for (longint unsigned k = 3; k < EXPONENT_LIMIT && !found; k++)
         if (gcd_of(p - 1, k) * gcd_of(q - 1, k) == 1) begin
            e = k;
            found = 1;
         end
      if (!found) begin
         ks.status = STATUS_NO_EXP;
         return ks;
      end
      // d*e = 1 + k*phi for the smallest k that gives d of at least 3.
      phi = (p - 1) * (q - 1);
      found = 0;
      for (longint unsigned k = 1; k <= 4 * e + 4 && !found; k++) begin
         x = 1 + k * phi;
         if (x % e == 0 && x / e >= 3) begin
            d = x / e;
            found = 1;
         end
      end
      ks.p = p[PrimeWidth-1:0];
      ks.q = q[PrimeWidth-1:0];
      ks.n = ModWidth'(p * q);
      ks.e = e[ExpWidth-1:0];
      ks.d = d[ModWidth-1:0];
      return ks;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch on key %0d: %s got %0d, expected %0d",
               keys_checked, what, got, want);
      fail_count++;
   endtask

   assign keys_waiting = expected_keys.size();

   // Predict on each request beat, compare on each response beat.
   always @(posedge clock) begin
      key_set_type want;
      if (reset) begin
         fail_count = 0;
         keys_checked = 0;
      end else begin
         if (req_valid && req_ready)
            expected_keys.push_back(compute_key_set(req_min_modulus));
         if (rsp_valid && rsp_ready) begin
            if (expected_keys.size() == 0) begin
               $display("response beat with no request waiting");
               fail_count++;
            end else begin
               want = expected_keys.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_prime_p !== want.p) report_mismatch("prime_p", rsp_prime_p, want.p);
               if (rsp_prime_q !== want.q) report_mismatch("prime_q", rsp_prime_q, want.q);
               if (rsp_modulus !== want.n) report_mismatch("modulus", rsp_modulus, want.n);
               if (rsp_public_exponent !== want.e)
                  report_mismatch("public_exponent", rsp_public_exponent, want.e);
               if (rsp_private_exponent !== want.d)
                  report_mismatch("private_exponent", rsp_private_exponent, want.d);
            end
            keys_checked++;
         end
      end
   end

endmodule

// ----- bench/rsa_small_key_generator_test.sv -----
// Testbench top for the small RSA key generator: drives request beats,
// stalls responses at random and gives the verdict from the checker.
// Depends on rskg_pkg, rsa_small_key_generator and its checker.
module rsa_small_key_generator_test;
   import rskg_pkg::*;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_ready;
   logic [MinWidth-1:0]    req_min_modulus = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 0;
   logic [PrimeWidth-1:0]  rsp_prime_p;
   logic [PrimeWidth-1:0]  rsp_prime_q;
   logic [ModWidth-1:0]    rsp_modulus;
   logic [ExpWidth-1:0]    rsp_public_exponent;
   logic [ModWidth-1:0]    rsp_private_exponent;
   logic [StatusWidth-1:0] rsp_status;
   int                     fail_count;
   int                     keys_waiting;
   int                     keys_checked;
   bit                     no_idle = 0;
   int                     bounds_sent = 0;
   int                     wide_bounds = 0;

   logic [MinWidth-1:0] directed_bounds[] = '{
      32'd0, 32'd1, 32'd2, 32'd48, 32'd120, 32'd2500, 32'd3720, 32'd3721,
      32'd3722, 32'd10000, 32'd123457, 32'd999999, 32'd65536, 32'hFFFF_FFFF,
      32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd4_000_000
   };

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   rsa_small_key_generator u_top (.*);

   rsa_small_key_generator_checker u_checker (.*);

   // Send one bound; valid stays high across back-to-back beats.
   task automatic send_bound(input logic [MinWidth-1:0] bound);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_min_modulus <= bound;
      do @(posedge clock); while (!req_ready);
      bounds_sent++;
      if (bound > 32'd16_777_216) wide_bounds++;
   endtask

   // Response side: random stall before each beat.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Stimulus: directed corners, then mostly small bounds to keep the
   // trial division short, with a few wide ones.
   initial begin
      logic [MinWidth-1:0] bound;
      repeat (3) @(posedge clock);
      reset <= 0;
      foreach (directed_bounds[i]) send_bound(directed_bounds[i]);
      // Let the block drain fully before the random part.
      req_valid <= 0;
      @(posedge clock);
      while (keys_waiting != 0) @(posedge clock);
      for (int i = 0; i < 100; i++) begin
         no_idle = (i >= 40 && i < 55);
         if ($urandom_range(0, 19) == 0) bound = $urandom_range(0, 32'h0400_0000);
         else if ($urandom_range(0, 9) == 0) bound = $urandom_range(0, 4000);
         else bound = $urandom_range(0, 32'h0010_0000);
         send_bound(bound);
      end
      no_idle = 0;
      // Two wide bounds so every input bit takes both values.
      send_bound(32'hAAAA_AAAA);
      send_bound(32'h5555_5555);
      req_valid <= 0;
      @(posedge clock);
      while (keys_waiting != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d bounds (%0d wide), checked %0d key sets",
               bounds_sent, wide_bounds, keys_checked);
      $display("corners covered: bounds below the window, extremes, idle-free stretch");
      if (fail_count == 0) begin
         $display("** rsa_small_key_generator: PASSED **");
      end else begin
         $display("** rsa_small_key_generator: FAILED **");
      end
      $finish;
   end

   initial begin
      #(12 * 80_000_000);
      $display("timeout with %0d key sets outstanding", keys_waiting);
      $display("** rsa_small_key_generator: FAILED **");
      $finish;
   end

endmodule
